[hw/rtl/delimited_field_splitter_macros.svh]
// ----------------------------------------------------------------------------
// delimited_field_splitter_macros.svh
// Assertion macros shared by the splitter's checker.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FIELD_SPLITTER_MACROS_SVH
`define DELIMITED_FIELD_SPLITTER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DFS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("splitter check failed");

// next-cycle implication, disabled while reset is asserted
`define DFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("splitter check failed");

`endif

[hw/rtl/dfs_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_pkg
// Types, limits and register indexes of the delimited field splitter.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam longint unsigned MAX_LINE_BYTES  = 64'd65536;
    localparam longint unsigned MAX_FIELD_COUNT = 64'd256;

    // saturation point of byte offsets
    localparam logic [15:0] POS_CAP =
        ((MAX_LINE_BYTES - 64'd1) > 64'd65535) ? 16'hFFFF : 16'(MAX_LINE_BYTES - 64'd1);

    // hard ceiling on fields per line
    localparam logic [8:0] FIELD_CAP =
        (MAX_FIELD_COUNT > 64'd256) ? 9'd256 : 9'(MAX_FIELD_COUNT);

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_ADDR_W-1:0] REG_DELIMITER  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_FIELDS = 2'd1;

    localparam logic [7:0] DELIMITER_RESET  = 8'd44;
    localparam logic [8:0] MAX_FIELDS_RESET = 9'd256;

    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_TUSER_W = 2;

    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] start;
        logic [8:0]  found;
        logic        ovf;
    } dfs_state_t;

    typedef struct packed {
        logic        field_valid;
        logic [15:0] field_start;
        logic [15:0] field_length;
        logic [7:0]  field_number;
        logic        line_end;
        logic [8:0]  field_count;
        logic        overflow;
    } dfs_result_t;

endpackage

[hw/rtl/delimited_field_splitter.sv]
// ----------------------------------------------------------------------------
// delimited_field_splitter
// Splits a byte stream of lines on a configurable delimiter and reports
// start, length and index of each field plus a per-line field count.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_        in         tdata[7:0] line_byte, tlast last_of_line
//  m_        out        tdata start/length/number/count, tuser valid/overflow,
//                       tlast line_end
//  cfg_      in         write-only register port (delimiter, max_fields)
//
//  While s_tready is high, one byte per clock goes through the step logic
//  into a single output register. s_tready stays high while that register
//  is empty or being drained, so a stalled m_ side holds at most one result.
//  Bytes that give no result leave the output register untouched.
//  aresetn is synchronous, active low; it clears all but the result register.
// ----------------------------------------------------------------------------
module delimited_field_splitter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] line_byte
    input  logic                           s_tlast,   // last_of_line
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] field_start, [31:16] field_length, [39:32] field_number,
    // [48:40] field_count, [55:49] zero
    output logic [dfs_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [dfs_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] field_valid, [1] overflow
    output logic                           m_tlast,   // line_end
    input  logic                           cfg_wr_en,
    input  logic [dfs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dfs_pkg::*;

    logic [7:0]  delimiter_reg;
    logic [8:0]  max_fields_reg;
    dfs_state_t  state_reg;
    dfs_state_t  state_next;
    dfs_result_t result_reg;
    dfs_result_t result_next;
    logic        result_hit;
    logic        m_valid_reg;
    logic        s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    dfs_field_logic u_step (
        .state        (state_reg),
        .delimiter    (delimiter_reg),
        .max_fields   (max_fields_reg),
        .line_byte    (s_tdata),
        .last_of_line (s_tlast),
        .state_next   (state_next),
        .result       (result_next),
        .result_valid (result_hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg  <= DELIMITER_RESET;
            max_fields_reg <= MAX_FIELDS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DELIMITER:  delimiter_reg  <= cfg_wdata[7:0];
                REG_MAX_FIELDS: max_fields_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept && result_hit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && result_hit) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = result_reg.line_end;
    assign m_tuser  = {result_reg.overflow, result_reg.field_valid};
    assign m_tdata  = {7'd0, result_reg.field_count, result_reg.field_number,
                       result_reg.field_length, result_reg.field_start};

endmodule

[hw/rtl/dfs_field_logic.sv]
// ----------------------------------------------------------------------------
// dfs_field_logic
// Per-item step: next line state and the result for one byte.
// ----------------------------------------------------------------------------
module dfs_field_logic (
    input  dfs_pkg::dfs_state_t  state,
    input  logic [7:0]           delimiter,
    input  logic [8:0]           max_fields,
    input  logic [7:0]           line_byte,
    input  logic                 last_of_line,
    output dfs_pkg::dfs_state_t  state_next,
    output dfs_pkg::dfs_result_t result,
    output logic                 result_valid
);
    import dfs_pkg::*;

    logic [8:0]  limit;
    logic        is_delim;
    logic        final_byte;
    logic        take;
    logic        at_cap;
    logic [16:0] len_raw;
    logic [15:0] len;
    logic        len_sat;
    logic        ovf_now;
    logic [8:0]  found_now;

    always_comb begin
        limit      = (max_fields > FIELD_CAP) ? FIELD_CAP : max_fields;
        is_delim   = (line_byte == delimiter);
        final_byte = last_of_line && !is_delim;
        take       = (state.found < limit) && (is_delim || final_byte);
        at_cap     = (state.pos >= POS_CAP);

        len_raw = (state.pos >= state.start)
                ? ({1'b0, state.pos} - {1'b0, state.start}) : 17'd0;
        len_raw = len_raw + {16'd0, final_byte};
        len_sat = len_raw[16];
        len     = len_sat ? 16'hFFFF : len_raw[15:0];

        ovf_now   = state.ovf || (take && len_sat) || (!last_of_line && at_cap);
        found_now = take ? state.found + 9'd1 : state.found;

        result.field_valid  = take;
        result.field_start  = take ? state.start : 16'd0;
        result.field_length = take ? len : 16'd0;
        result.field_number = take ? state.found[7:0] : 8'd0;
        result.line_end     = last_of_line;
        result.field_count  = last_of_line ? found_now : 9'd0;
        result.overflow     = ovf_now;
        result_valid        = take || last_of_line;

        if (last_of_line) begin
            state_next = '0;
        end else begin
            state_next.pos   = at_cap ? state.pos : state.pos + 16'd1;
            state_next.start = take ? (at_cap ? POS_CAP : state.pos + 16'd1) : state.start;
            state_next.found = found_now;
            state_next.ovf   = ovf_now;
        end
    end

endmodule

[hw/rtl/dfs_checker.sv]
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks of the splitter's result channel.
// ----------------------------------------------------------------------------
`include "delimited_field_splitter_macros.svh"

module dfs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dfs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [dfs_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                           m_tlast
);

    // a stalled result holds
    `DFS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // an empty output stage never back-pressures the input
    `DFS_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // count only on the line-closing item
    `DFS_ASSERT_SAME(a_count_on_end, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[48:40] == 9'd0)

    // field info is zero when no field is reported
    `DFS_ASSERT_SAME(a_field_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[39:0] == 40'd0)

endmodule

bind delimited_field_splitter dfs_checker u_dfs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

[tb/delimited_field_splitter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_splitter_tb
// Self-checking bench for the field splitter. Lines of bytes go in through
// the s_ stream. An in-bench tracker follows the line state and queues the
// field reports that each byte should produce. Every report taken from the
// m_ stream is compared against that queue. Runs cover several delimiter and
// field-limit settings and random stalls on both streams.
// ----------------------------------------------------------------------------
module delimited_field_splitter_tb;
    import dfs_pkg::*;

    // addresses beyond the register map; writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [7:0]            FILL_CHAR    = 8'h61;

    class field_report_board;
        logic [7:0]   delim;
        logic [8:0]   max_fields;
        logic [15:0]  cur_pos;
        logic [15:0]  field_start;
        logic [8:0]   found;
        logic         ovf;
        int unsigned  miscompares;
        dfs_result_t  due_reports[$];

        function new();
            delim       = DELIMITER_RESET;
            max_fields  = MAX_FIELDS_RESET;
            cur_pos     = '0;
            field_start = '0;
            found       = '0;
            ovf         = 1'b0;
            miscompares = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_DELIMITER:  delim      = data[7:0];
                REG_MAX_FIELDS: max_fields = data;
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            dfs_result_t r;
            logic [16:0] len;
            logic [8:0]  lim;
            logic        got_field;
            r         = '0;
            got_field = 1'b0;
            lim       = (max_fields > FIELD_CAP) ? FIELD_CAP : max_fields;
            if (found < lim && (b == delim || last)) begin
                len = (cur_pos >= field_start) ? {1'b0, cur_pos - field_start} : 17'd0;
                if (b != delim) len = len + 17'd1;     // final byte belongs to the field
                if (len > 17'h0FFFF) begin
                    len = 17'h0FFFF;
                    ovf = 1'b1;
                end
                got_field      = 1'b1;
                r.field_valid  = 1'b1;
                r.field_start  = field_start;
                r.field_length = len[15:0];
                r.field_number = found[7:0];
                found          = found + 9'd1;
                field_start    = (cur_pos >= POS_CAP) ? POS_CAP : cur_pos + 16'd1;
            end
            if (!last) begin
                if (cur_pos >= POS_CAP) ovf = 1'b1;
                else cur_pos = cur_pos + 16'd1;
            end
            if (got_field || last) begin
                r.line_end    = last;
                r.field_count = last ? found : 9'd0;
                r.overflow    = ovf;
                due_reports.push_back(r);
            end
            if (last) begin
                cur_pos     = '0;
                field_start = '0;
                found       = '0;
                ovf         = 1'b0;
            end
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                miscompares++;
            end
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user,
                                   logic last);
            dfs_result_t want;
            if (due_reports.size() == 0) begin
                $error("report with none pending: tdata %h tuser %b tlast %b", data, user, last);
                miscompares++;
                return;
            end
            want = due_reports.pop_front();
            compare("field_valid", want.field_valid, user[0]);
            compare("field_start", want.field_start, data[15:0]);
            compare("field_length", want.field_length, data[31:16]);
            compare("field_number", want.field_number, data[39:32]);
            compare("line_end", want.line_end, last);
            compare("field_count", want.field_count, data[48:40]);
            compare("overflow", want.overflow, user[1]);
            compare("tdata pad", 32'd0, data[55:49]);
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    field_report_board board = new();
    bit          src_gaps    = 1'b1;
    bit          sink_stalls = 1'b1;
    int unsigned sink_hold   = 0;

    delimited_field_splitter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4ms;
        $display("delimited_field_splitter: mismatch");
        $finish;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
            sink_hold <= idle_len();
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) board.check_report(m_tdata, m_tuser, m_tlast);
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        int unsigned n;
        n = src_gaps ? idle_len() : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_fill(logic [7:0] b, int unsigned n);
        repeat (n) send_byte(b, 1'b0);
    endtask

    // wait for every queued report, then cover an item still in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (board.due_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        board.write_reg(addr, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_line(int unsigned n_bytes);
        int unsigned pct;
        logic [7:0]  b;
        pct      = $urandom_range(0, 60);
        src_gaps = ($urandom_range(0, 3) != 0);
        for (int unsigned k = 0; k < n_bytes; k++) begin
            b = ($urandom_range(0, 99) < pct) ? board.delim : 8'($urandom());
            send_byte(b, k == n_bytes - 1);
        end
    endtask

    task automatic run_random(int unsigned budget);
        int unsigned sent;
        int unsigned n;
        int unsigned r;
        sent        = 0;
        sink_stalls = ($urandom_range(0, 4) != 0);
        while (sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 80) n = $urandom_range(1, 12);
            else if (r < 97) n = $urandom_range(13, 40);
            else n = $urandom_range(60, 120);
            send_random_line(n);
            sent += n;
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic new_setting(logic [7:0] d, logic [8:0] m);
        settle();
        program_reg(REG_DELIMITER, {1'($urandom_range(0, 1)), d});
        program_reg(REG_MAX_FIELDS, m);
        run_random(50);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: comma, 256 fields
        send_byte(FILL_CHAR, 1'b1);                 // one-byte line
        send_byte(8'd44, 1'b1);                     // lone delimiter, no empty tail
        send_byte(8'd44, 1'b0);                     // empty fields, then final byte
        send_byte(8'd44, 1'b0);
        send_byte(8'h62, 1'b1);
        send_byte(8'h78, 1'b0);                     // trailing delimiter
        send_byte(8'h79, 1'b0);
        send_byte(8'd44, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(8'd44, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);

        // field limit: every byte a delimiter, just past 256
        src_gaps = 1'b0;
        send_fill(8'd44, 259);
        send_byte(8'd44, 1'b1);
        src_gaps = 1'b1;

        run_random(50);

        // no fields at all; stray register addresses must be ignored
        settle();
        program_reg(REG_DELIMITER, 9'd0);
        program_reg(REG_MAX_FIELDS, 9'd0);
        program_reg(REG_SPARE_LO, 9'($urandom_range(0, 511)));
        program_reg(REG_SPARE_HI, 9'($urandom_range(0, 511)));
        send_byte(FILL_CHAR, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'h62, 1'b1);
        run_random(50);

        new_setting(8'hFF, 9'd1);
        new_setting(8'($urandom()), 9'd2);
        new_setting(8'($urandom()), 9'd3);
        new_setting(8'($urandom()), 9'd511);        // above 256 acts as 256
        new_setting(8'($urandom()), 9'd257);
        new_setting(8'($urandom()), 9'($urandom_range(4, 255)));
        new_setting(8'd44, 9'd256);

        settle();
        repeat (8) @(posedge aclk);
        if (board.miscompares == 0) begin
            $display("delimited_field_splitter: match");
        end else begin
            $display("delimited_field_splitter: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dfs_pkg.sv
hw/rtl/dfs_field_logic.sv
hw/rtl/delimited_field_splitter.sv
hw/rtl/dfs_checker.sv
tb/delimited_field_splitter_tb.sv
